// ===== design/ttf_pkg.sv =====
// Shared types, constants and defaults for the triangle tangent frame unit.
package ttf_pkg;

    // default widths
    localparam int TTF_COORD_W = 24;
    localparam int TTF_UNIT_W  = 16;

    // shared signed multiplier operand width
    localparam int MUL_W = 31;

    // normalized magnitudes lie in [2^29, 2^30)
    localparam int NRM_W = 30;
    // sum of squares and square root widths
    localparam int SQ_W  = 62;
    localparam int LEN_W = 31;

    // job queue depth
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // back end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_ABS,
        S_NORM,
        S_SQM,
        S_SQA,
        S_ROOT,
        S_DIVI,
        S_DIV,
        S_OUT
    } t_bstate;

    // which vector the sequencer is working on
    typedef enum logic [1:0] {
        G_DET,
        G_TAN,
        G_BIN,
        G_CRS
    } t_grp;

endpackage

// ===== design/ttf_queue.sv =====
// Short job queue between the vertex front end and the frame back end.
module ttf_queue
    import ttf_pkg::*;
#(
    parameter int W = 250
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_qstat       o_stat
);

    logic [W-1:0] r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== design/ttf_front.sv =====
// Vertex front end: groups vertices into triangles and forms the deltas.
module ttf_front
    import ttf_pkg::*;
#(
    parameter int COORD_WIDTH = TTF_COORD_W,
    parameter int IN_W        = 120,
    parameter int JW          = 250
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [IN_W-1:0] i_data,
    input  logic            i_start,
    output logic            o_ready,
    input  t_qstat          i_qstat,
    output logic            o_push,
    output logic [JW-1:0]   o_job
);

    localparam int CW     = COORD_WIDTH;
    localparam int DSHIFT = (CW > 30) ? CW - 30 : 0;
    localparam int DW     = CW + 1 - DSHIFT;

    logic [1:0] r_phase;
    logic [1:0] ph;
    logic       acc;
    logic signed [CW-1:0] p [3];
    logic signed [CW-1:0] u, v;
    logic signed [CW-1:0] r_p0 [3];
    logic signed [CW-1:0] r_p1 [3];
    logic signed [CW-1:0] r_u0, r_v0, r_u1, r_v1;

    // exact difference, floor-shifted to fit the multiplier
    function automatic logic signed [DW-1:0] delta(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        logic signed [CW:0] s;
        d = (CW+1)'(a) - (CW+1)'(b);
        s = d >>> DSHIFT;
        return s[DW-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p[i] = i_data[i*CW +: CW];
        end
        u = i_data[3*CW +: CW];
        v = i_data[4*CW +: CW];
    end

    assign o_ready = !i_qstat.full;
    assign acc     = i_valid && o_ready;
    // start mark and the unused phase code both mean first corner
    assign ph      = (i_start || r_phase == 2'd3) ? 2'd0 : r_phase;
    assign o_push  = acc && (ph == 2'd2);

    // job: e1 xyz, e2 xyz, du1, dv1, du2, dv2 from the lowest bits up
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_job[i*DW +: DW]     = delta(r_p1[i], r_p0[i]);
            o_job[(3+i)*DW +: DW] = delta(p[i], r_p0[i]);
        end
        o_job[6*DW +: DW] = delta(r_u1, r_u0);
        o_job[7*DW +: DW] = delta(r_v1, r_v0);
        o_job[8*DW +: DW] = delta(u, r_u0);
        o_job[9*DW +: DW] = delta(v, r_v0);
    end

    // held corners
    always_ff @(posedge i_clk) begin
        if (acc && ph == 2'd0) begin
            r_p0 <= p;
            r_u0 <= u;
            r_v0 <= v;
        end
        if (acc && ph == 2'd1) begin
            r_p1 <= p;
            r_u1 <= u;
            r_v1 <= v;
        end
    end

    // corner phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (acc) begin
            r_phase <= (ph == 2'd2) ? 2'd0 : ph + 2'd1;
        end
    end

endmodule

// ===== design/ttf_back.sv =====
// Frame back end: shared multiplier, normalizer, square root and divider.
module ttf_back
    import ttf_pkg::*;
#(
    parameter int COORD_WIDTH = TTF_COORD_W,
    parameter int UNIT_WIDTH  = TTF_UNIT_W,
    parameter int JW          = 250
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_qstat                  i_qstat,
    input  logic [JW-1:0]           i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [9*UNIT_WIDTH-1:0] o_data,
    output logic                    o_degen
);

    localparam int CW     = COORD_WIDTH;
    localparam int UW     = UNIT_WIDTH;
    localparam int DSHIFT = (CW > 30) ? CW - 30 : 0;
    localparam int DW     = CW + 1 - DSHIFT;
    localparam int VW     = (2*DW > 2*UW) ? 2*DW + 1 : 2*UW + 1;
    localparam int MAGW   = VW - 1;
    localparam int F      = UW - 2;
    localparam int QB     = F + 1;
    localparam int DVW    = NRM_W + F + 1;
    localparam int PW     = 2 * MUL_W;

    t_bstate r_state, n_state;
    t_grp    r_grp, n_grp;
    logic [2:0] r_term, n_term;
    logic [4:0] r_cnt, n_cnt;
    logic       r_degen, n_degen;
    logic       r_neg, n_neg;

    logic signed [DW-1:0] r_e1 [3];
    logic signed [DW-1:0] r_e2 [3];
    logic signed [DW-1:0] r_du1, r_dv1, r_du2, r_dv2;

    logic signed [PW-1:0] r_prod, n_prod;
    logic signed [VW-1:0] r_acc, n_acc;
    logic signed [VW-1:0] r_vec [3];
    logic signed [VW-1:0] n_vec [3];
    logic [MAGW-1:0]      r_mag [3];
    logic [MAGW-1:0]      n_mag [3];
    logic [MAGW-1:0]      r_max, n_max;
    logic [SQ_W-1:0]      r_sum, n_sum, r_rn, n_rn, r_rr, n_rr;
    logic [LEN_W-1:0]     r_len, n_len, r_rem, n_rem;
    logic [QB-1:0]        r_dq, n_dq;
    logic signed [UW-1:0] r_t [3];
    logic signed [UW-1:0] r_b [3];
    logic signed [UW-1:0] r_n [3];
    logic signed [UW-1:0] n_t [3];
    logic signed [UW-1:0] n_b [3];
    logic signed [UW-1:0] n_n [3];

    logic                  r_ov, n_ov;
    logic [9*UW-1:0]       r_odata, n_odata;
    logic                  r_odeg, n_odeg;

    logic signed [MUL_W-1:0] opa, opb;
    logic [1:0] ci, i1, i2;

    // multiplier operand select
    always_comb begin
        ci  = r_term[2:1];
        opa = '0;
        opb = '0;
        case (ci)
            2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            default: begin i1 = 2'd0; i2 = 2'd1; end
        endcase
        if (r_state == S_SQM) begin
            opa = MUL_W'($signed({1'b0, r_mag[r_term[1:0]][NRM_W-1:0]}));
            opb = opa;
        end else begin
            case (r_grp)
                G_DET: begin
                    opa = r_term[0] ? MUL_W'(r_du2) : MUL_W'(r_du1);
                    opb = r_term[0] ? MUL_W'(r_dv1) : MUL_W'(r_dv2);
                end
                G_TAN: begin
                    opa = r_term[0] ? MUL_W'(r_dv1) : MUL_W'(r_dv2);
                    opb = r_term[0] ? MUL_W'(r_e2[ci]) : MUL_W'(r_e1[ci]);
                end
                G_BIN: begin
                    opa = r_term[0] ? MUL_W'(r_du2) : MUL_W'(r_du1);
                    opb = r_term[0] ? MUL_W'(r_e1[ci]) : MUL_W'(r_e2[ci]);
                end
                default: begin
                    opa = r_term[0] ? MUL_W'(r_t[i2]) : MUL_W'(r_t[i1]);
                    opb = r_term[0] ? MUL_W'(r_b[i1]) : MUL_W'(r_b[i2]);
                end
            endcase
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_qstat.empty;

    // sequencer
    always_comb begin
        logic signed [VW-1:0] diff;
        logic signed [VW-1:0] av [3];
        logic [63:0]          mx;
        logic [SQ_W-1:0]      bit62, rb;
        logic [DVW-1:0]       dvd;
        logic [LEN_W:0]       t2;
        logic                 qb;
        logic signed [UW-1:0] qv;
        n_state = r_state;
        n_grp   = r_grp;
        n_term  = r_term;
        n_cnt   = r_cnt;
        n_degen = r_degen;
        n_neg   = r_neg;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_vec   = r_vec;
        n_mag   = r_mag;
        n_max   = r_max;
        n_sum   = r_sum;
        n_rn    = r_rn;
        n_rr    = r_rr;
        n_len   = r_len;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_t     = r_t;
        n_b     = r_b;
        n_n     = r_n;
        n_ov    = r_ov && !i_ready;
        n_odata = r_odata;
        n_odeg  = r_odeg;
        diff    = r_acc - VW'(r_prod);
        mx      = 64'(r_max);
        bit62   = SQ_W'(1) << {r_cnt, 1'b0};
        rb      = r_rr + bit62;
        dvd     = DVW'({r_mag[r_term[1:0]][NRM_W-1:0], F'(0)}) + DVW'(r_len >> 1);
        t2      = {r_rem, r_dq[QB-1]};
        qb      = (t2 >= {1'b0, r_len});
        qv      = '0;
        for (int i = 0; i < 3; i++) begin
            av[i] = r_vec[i][VW-1] ? -r_vec[i] : r_vec[i];
        end
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = S_MUL;
                    n_grp   = G_DET;
                    n_term  = 3'd0;
                    n_degen = 1'b0;
                end
            end
            S_MUL: begin
                n_prod  = opa * opb;
                n_state = S_ACC;
            end
            S_ACC: begin
                if (!r_term[0]) begin
                    n_acc   = VW'(r_prod);
                    n_term  = r_term + 3'd1;
                    n_state = S_MUL;
                end else if (r_grp == G_DET) begin
                    n_neg  = diff[VW-1];
                    n_term = 3'd0;
                    if (diff == '0) begin
                        n_degen = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_grp   = G_TAN;
                        n_state = S_MUL;
                    end
                end else begin
                    // determinant sign flips tangent and binormal
                    n_vec[r_term[2:1]] = (r_neg && r_grp != G_CRS) ? -diff : diff;
                    if (r_term == 3'd5) begin
                        n_state = S_ABS;
                    end else begin
                        n_term  = r_term + 3'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    n_mag[i] = av[i][MAGW-1:0];
                end
                n_max = n_mag[0];
                if (n_mag[1] > n_max) n_max = n_mag[1];
                if (n_mag[2] > n_max) n_max = n_mag[2];
                if (n_max == '0) begin
                    n_degen = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // bring the largest magnitude into [2^29, 2^30)
                if (mx >= (64'd1 << 38)) begin
                    n_max = r_max >> 8;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] >> 8;
                end else if (mx >= (64'd1 << 30)) begin
                    n_max = r_max >> 1;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] >> 1;
                end else if (mx < (64'd1 << 21)) begin
                    n_max = r_max << 8;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] << 8;
                end else if (mx < (64'd1 << 29)) begin
                    n_max = r_max << 1;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] << 1;
                end else begin
                    n_sum   = '0;
                    n_term  = 3'd0;
                    n_state = S_SQM;
                end
            end
            S_SQM: begin
                n_prod  = opa * opb;
                n_state = S_SQA;
            end
            S_SQA: begin
                n_sum = r_sum + r_prod[SQ_W-1:0];
                if (r_term == 3'd2) begin
                    n_rn    = n_sum;
                    n_rr    = '0;
                    n_cnt   = 5'd30;
                    n_state = S_ROOT;
                end else begin
                    n_term  = r_term + 3'd1;
                    n_state = S_SQM;
                end
            end
            S_ROOT: begin
                // one result bit per cycle
                if (r_rn >= rb) begin
                    n_rn = r_rn - rb;
                    n_rr = (r_rr >> 1) + bit62;
                end else begin
                    n_rr = r_rr >> 1;
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_len   = n_rr[LEN_W-1:0];
                    n_term  = 3'd0;
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                n_rem   = LEN_W'(dvd >> QB);
                n_dq    = dvd[QB-1:0];
                n_cnt   = 5'(QB - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring division, quotient shifts in from the low end
                n_rem = qb ? LEN_W'(t2 - {1'b0, r_len}) : t2[LEN_W-1:0];
                n_dq  = {r_dq[QB-2:0], qb};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    qv = UW'(n_dq);
                    if (r_vec[r_term[1:0]][VW-1]) qv = -qv;
                    case (r_grp)
                        G_TAN:   n_t[r_term[1:0]] = qv;
                        G_BIN:   n_b[r_term[1:0]] = qv;
                        default: n_n[r_term[1:0]] = qv;
                    endcase
                    if (r_term == 3'd2) begin
                        n_term = 3'd0;
                        case (r_grp)
                            G_TAN: begin
                                n_grp   = G_BIN;
                                n_state = S_MUL;
                            end
                            G_BIN: begin
                                n_grp   = G_CRS;
                                n_state = S_MUL;
                            end
                            default: n_state = S_OUT;
                        endcase
                    end else begin
                        n_term  = r_term + 3'd1;
                        n_state = S_DIVI;
                    end
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_odeg  = r_degen;
                    n_odata = r_degen ? '0 :
                              {n_n[2], n_n[1], n_n[0], n_b[2], n_b[1], n_b[0],
                               n_t[2], n_t[1], n_t[0]};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // job latch on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= i_job[i*DW +: DW];
                r_e2[i] <= i_job[(3+i)*DW +: DW];
            end
            r_du1 <= i_job[6*DW +: DW];
            r_dv1 <= i_job[7*DW +: DW];
            r_du2 <= i_job[8*DW +: DW];
            r_dv2 <= i_job[9*DW +: DW];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_grp   <= n_grp;
        r_term  <= n_term;
        r_cnt   <= n_cnt;
        r_degen <= n_degen;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_vec   <= n_vec;
        r_mag   <= n_mag;
        r_max   <= n_max;
        r_sum   <= n_sum;
        r_rn    <= n_rn;
        r_rr    <= n_rr;
        r_len   <= n_len;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_t     <= n_t;
        r_b     <= n_b;
        r_n     <= n_n;
        r_odata <= n_odata;
        r_odeg  <= n_odeg;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_odata;
    assign o_degen = r_odeg;

    // degenerate frames carry zero vectors
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_odeg |-> r_odata == '0)
        else $error("degenerate frame with nonzero vectors");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_len)
        else $error("divider remainder out of range");

    // root step count in range
    a_root_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROOT |-> r_cnt <= 5'd30)
        else $error("square root step count out of range");

    // a job is taken only in idle, and the sequencer goes on to the determinant products
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_MUL && r_grp == G_DET)
        else $error("job popped outside idle");

endmodule

// ===== design/triangle_tangent_frame_unit.sv =====
// Top level of the per-face tangent, binormal and normal frame unit.
// Vertices are accepted one per cycle while the two-entry job queue has room.
// Each frame is built after its third vertex: determinant, then per vector
// six products, normalize, 31-step square root and three 15-step restoring divides; a zero
// determinant sends its frame straight to the output. The shared back end works on one triangle at a time.
// Reset (synchronous, active low) clears the corner phase, queue and sequencer.
module triangle_tangent_frame_unit
    import ttf_pkg::*;
#(
    parameter int COORD_WIDTH = TTF_COORD_W,
    parameter int UNIT_WIDTH  = TTF_UNIT_W,
    localparam int IN_W  = ((5*COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((9*UNIT_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [IN_W-1:0]  s_axis_tdata,
    // start_mesh
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tangent_x/y/z, binormal_x/y/z, normal_x/y/z
    output logic [OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic             m_axis_tuser
);

    localparam int DSHIFT = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
    localparam int DW     = COORD_WIDTH + 1 - DSHIFT;
    localparam int JW     = 10 * DW;

    t_qstat                  qstat;
    logic                    push, pop;
    logic [JW-1:0]           job_in, job_out;
    logic [9*UNIT_WIDTH-1:0] frame;

    ttf_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .IN_W        (IN_W),
        .JW          (JW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (job_in)
    );

    ttf_queue #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_stat  (qstat)
    );

    ttf_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .UNIT_WIDTH  (UNIT_WIDTH),
        .JW          (JW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (frame),
        .o_degen (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'(frame);

endmodule
